@@ rtl/tgp_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tgp_pkg: shared types and constants of the tile glyph pixel renderer
// word layouts, register indexes, palette reset values, control structs
// ---------------------------------------------------------------------------
package tgp_pkg;

    localparam int GLYPH_COUNT_DEF = 128;

    localparam int CODE_W  = 7;
    localparam int ROW_W   = 3;
    localparam int CELL_W  = 5;
    localparam int PLANE_W = 8;
    localparam int GLYPH_W = 2 * PLANE_W;
    localparam int CHAN_W  = 8;
    localparam int COLOR_W = 3 * CHAN_W;
    localparam int COORD_W = CELL_W + ROW_W;

    // request types
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_PUT  = 1'b1;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = COLOR_W;

    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_0   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_1   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_2   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_3   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SKIP_ZERO = 3'd4;

    localparam logic [COLOR_W-1:0] COLOR_0_RST = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] COLOR_1_RST = 24'hAAAAAA;
    localparam logic [COLOR_W-1:0] COLOR_2_RST = 24'h555555;
    localparam logic [COLOR_W-1:0] COLOR_3_RST = 24'h000000;

    typedef struct packed {
        logic               req_type;
        logic [CODE_W-1:0]  char_code;
        logic [ROW_W-1:0]   glyph_row;
        logic [PLANE_W-1:0] plane_low;
        logic [PLANE_W-1:0] plane_high;
        logic [CELL_W-1:0]  cell_x;
        logic [CELL_W-1:0]  cell_y;
    } req_word_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic               write_enable;
        logic               last;
    } pix_word_t;

    // controller to datapath
    typedef struct packed {
        logic clear_step;   // zero one glyph store entry
        logic load_row;     // write the request's row into the store
        logic start;        // latch a put request, read its row 0
        logic prime;        // take row 0 into the shifter, read row 1
        logic emit;         // produce one pixel into the output register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic out_free;
        logic last_pixel;
    } dp_status_t;

endpackage

@@ rtl/tile_glyph_pixel_renderer.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tile_glyph_pixel_renderer: 2bpp planar text-mode character generator
// loads glyph rows into a store and draws 8x8 characters as pixel words
// ---------------------------------------------------------------------------
// load word: writes one glyph row into the store, no output
// put word: the prime state takes row 0 into the shifter, then the emit state
//   gives one pixel a cycle while the output is not stalled; the input stays
//   stalled until the last pixel of the character is emitted
// reset: the glyph store, GLYPH_COUNT*8 entries (1024 by default), is zeroed
//   one entry a cycle with req_stall high; registers take palette defaults
module tile_glyph_pixel_renderer
#(
    parameter int GLYPH_COUNT = tgp_pkg::GLYPH_COUNT_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            req_valid,
    output logic                            req_stall,
    input  tgp_pkg::req_word_t              req_word,
    // pixel channel
    output logic                            pix_valid,
    input  logic                            pix_stall,
    output tgp_pkg::pix_word_t              pix_word,
    // configuration writes
    input  logic                            cfg_write,
    input  logic [tgp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tgp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tgp_pkg::*;

    // command and status between sequencer and datapath
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer: clearing pass, then idle / prime / emit per put word
    tgp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req_word.req_type),
        .status    (status),
        .cmd       (cmd),
        .req_stall (req_stall)
    );

    // datapath: glyph store, row shifter, palette lookup, output register
    tgp_datapath
    #(
        .GLYPH_COUNT (GLYPH_COUNT)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req_word  (req_word),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_stall (pix_stall),
        .pix_valid (pix_valid),
        .pix_word  (pix_word)
    );

endmodule

@@ rtl/tgp_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tgp_ctrl: sequencer of the tile glyph pixel renderer
// store clearing pass, request intake, row prefetch and pixel emission
// ---------------------------------------------------------------------------
module tgp_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_type,
    input  tgp_pkg::dp_status_t status,
    output tgp_pkg::ctrl_cmd_t  cmd,
    output logic               req_stall
);
    import tgp_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PRIME,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;
    logic   stall_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_type == REQ_PUT)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_PRIME;
                    end
                    else
                    begin
                        cmd.load_row = 1'b1;
                    end
                end
            end
            S_PRIME:
            begin
                cmd.prime  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last_pixel)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
        stall_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            stall_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
        end
    end

    assign req_stall = stall_reg;

endmodule

@@ rtl/tgp_datapath.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tgp_datapath: glyph store, palette registers and pixel generator
// one read port feeds a two-plane row shifter, one output register
// ---------------------------------------------------------------------------
module tgp_datapath
#(
    parameter int GLYPH_COUNT = tgp_pkg::GLYPH_COUNT_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  tgp_pkg::ctrl_cmd_t                  cmd,
    output tgp_pkg::dp_status_t                 status,
    input  tgp_pkg::req_word_t                  req_word,
    input  logic                                cfg_write,
    input  logic [tgp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tgp_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                pix_stall,
    output logic                                pix_valid,
    output tgp_pkg::pix_word_t                  pix_word
);
    import tgp_pkg::*;

    localparam int DEPTH = GLYPH_COUNT * 8;
    localparam int GW    = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int AW    = GW + ROW_W;
    localparam int CW    = (GW > CODE_W) ? GW : CODE_W;

    function automatic logic [GW-1:0] glyph_idx(input logic [CODE_W-1:0] code);
        logic [CW-1:0] wide;
        wide = CW'(code);
        return wide[GW-1:0];
    endfunction

    function automatic logic glyph_hit(input logic [CODE_W-1:0] code);
        return {1'b0, CW'(code)} < (CW + 1)'(GLYPH_COUNT);
    endfunction

    // glyph store
    logic [GLYPH_W-1:0] gmem [DEPTH];
    logic [GLYPH_W-1:0] mem_q_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [GLYPH_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;

    logic [AW-1:0]      clr_cnt_reg;

    // latched put request
    logic [GW-1:0]      code_reg;
    logic               hit_reg;
    logic [CELL_W-1:0]  cx_reg;
    logic [CELL_W-1:0]  cy_reg;
    logic [ROW_W-1:0]   dx_reg;
    logic [ROW_W-1:0]   dy_reg;
    logic [PLANE_W-1:0] lo_reg;
    logic [PLANE_W-1:0] hi_reg;
    logic [PLANE_W-1:0] fetch_lo;
    logic [PLANE_W-1:0] fetch_hi;
    logic               row_end;

    // palette
    logic [COLOR_W-1:0] color_reg [4];
    logic               skip_reg;

    logic [1:0]         pix_idx;
    logic [COLOR_W-1:0] pix_color;
    logic               pix_we;
    pix_word_t          pix_next;
    pix_word_t          pix_word_reg;
    logic               pix_valid_reg;

    assign row_end = (dx_reg == ROW_W'(7));

    assign mem_we    = cmd.clear_step || (cmd.load_row && glyph_hit(req_word.char_code));
    assign mem_waddr = cmd.clear_step ? clr_cnt_reg
                                      : {glyph_idx(req_word.char_code), req_word.glyph_row};
    assign mem_wdata = cmd.clear_step ? '0 : {req_word.plane_high, req_word.plane_low};

    // prime fetches row 1, each row end fetches the row after the one being loaded
    assign mem_re    = cmd.start || cmd.prime || (cmd.emit && row_end);
    assign mem_raddr = cmd.start ? {glyph_idx(req_word.char_code), ROW_W'(0)}
                     : cmd.prime ? {code_reg, dy_reg + ROW_W'(1)}
                                 : {code_reg, dy_reg + ROW_W'(2)};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            gmem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            mem_q_reg <= gmem[mem_raddr];
        end
    end

    // glyphs beyond the store read as all zero
    assign fetch_lo = hit_reg ? mem_q_reg[PLANE_W-1:0] : '0;
    assign fetch_hi = hit_reg ? mem_q_reg[GLYPH_W-1:PLANE_W] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg[0] <= COLOR_0_RST;
            color_reg[1] <= COLOR_1_RST;
            color_reg[2] <= COLOR_2_RST;
            color_reg[3] <= COLOR_3_RST;
            skip_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_COLOR_0:   color_reg[0] <= cfg_data;
                REG_COLOR_1:   color_reg[1] <= cfg_data;
                REG_COLOR_2:   color_reg[2] <= cfg_data;
                REG_COLOR_3:   color_reg[3] <= cfg_data;
                REG_SKIP_ZERO: skip_reg     <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // pixel generation: column 0 is bit 7 of each plane
    assign pix_idx = {hi_reg[PLANE_W-1], lo_reg[PLANE_W-1]};

    always_comb
    begin
        case (pix_idx)
            2'd0:    pix_color = color_reg[0];
            2'd1:    pix_color = color_reg[1];
            2'd2:    pix_color = color_reg[2];
            default: pix_color = color_reg[3];
        endcase
        pix_we                = !(skip_reg && (pix_idx == 2'd0));
        pix_next.pixel_x      = {cx_reg, dx_reg};
        pix_next.pixel_y      = {cy_reg, dy_reg};
        pix_next.red          = pix_we ? pix_color[23:16] : '0;
        pix_next.green        = pix_we ? pix_color[15:8]  : '0;
        pix_next.blue         = pix_we ? pix_color[7:0]   : '0;
        pix_next.write_enable = pix_we;
        pix_next.last         = status.last_pixel;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            code_reg <= glyph_idx(req_word.char_code);
            hit_reg  <= glyph_hit(req_word.char_code);
            cx_reg   <= req_word.cell_x;
            cy_reg   <= req_word.cell_y;
        end
        if (cmd.prime || (cmd.emit && row_end))
        begin
            lo_reg <= fetch_lo;
            hi_reg <= fetch_hi;
        end
        else if (cmd.emit)
        begin
            lo_reg <= {lo_reg[PLANE_W-2:0], 1'b0};
            hi_reg <= {hi_reg[PLANE_W-2:0], 1'b0};
        end
        if (cmd.emit)
        begin
            pix_word_reg <= pix_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dx_reg        <= '0;
            dy_reg        <= '0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                dx_reg <= '0;
                dy_reg <= '0;
            end
            else if (cmd.emit)
            begin
                dx_reg <= dx_reg + ROW_W'(1);
                if (row_end)
                begin
                    dy_reg <= dy_reg + ROW_W'(1);
                end
            end
            if (cmd.emit)
            begin
                pix_valid_reg <= 1'b1;
            end
            else if (!pix_stall)
            begin
                pix_valid_reg <= 1'b0;
            end
        end
    end

    assign status.clear_done = (clr_cnt_reg == AW'(DEPTH - 1));
    assign status.out_free   = !pix_valid_reg || !pix_stall;
    assign status.last_pixel = row_end && (dy_reg == ROW_W'(7));

    assign pix_valid = pix_valid_reg;
    assign pix_word  = pix_word_reg;

endmodule

@@ rtl/tgp_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tgp_checker: port-level checks of the tile glyph pixel renderer
// handshake hold, pixel stream continuity and put word stall
// ---------------------------------------------------------------------------
module tgp_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input tgp_pkg::req_word_t req_word,
    input logic               pix_valid,
    input logic               pix_stall,
    input tgp_pkg::pix_word_t pix_word
);
    import tgp_pkg::*;

    // stalled pixel word holds
    a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_stall |=> pix_valid && $stable(pix_word))
        else $error("pixel word changed while stalled");

    // a character's pixels follow each other without gaps
    a_pix_stream: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_stall && !pix_word.last |=> pix_valid)
        else $error("gap inside a character's pixel stream");

    // columns advance by one within a row
    a_pix_column: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_stall && !pix_word.last && (pix_word.pixel_x[2:0] != 3'd7)
        |=> pix_word.pixel_x == ($past(pix_word.pixel_x) + 8'd1))
        else $error("pixel column did not advance");

    // a put word blocks the next request
    a_put_stall: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req_word.req_type == REQ_PUT) |=> req_stall)
        else $error("request taken during a put");

endmodule

bind tile_glyph_pixel_renderer tgp_checker u_tgp_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_word  (pix_word)
);

@@ verif/tile_glyph_pixel_renderer_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tile_glyph_pixel_renderer_tb: self-checking bench for the glyph renderer
// loads glyph rows and draws characters under several palette settings,
// predicts every pixel word and checks each one as it leaves the block
// ---------------------------------------------------------------------------
module tile_glyph_pixel_renderer_tb;

    import tgp_pkg::*;

    // run bounds
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int ITEMS_PER_SET  = 45;
    localparam int PUT_HOLD       = 70;
    localparam int LOAD_SETTLE    = 8;
    localparam int STORE_ROWS     = GLYPH_COUNT_DEF * 8;
    localparam int MAX_PRINTED    = 40;

    // register indexes with nothing behind them
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_5 = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_7 = 3'd7;

    logic clk;
    logic rst_n;

    // request side
    logic       req_valid;
    logic       req_stall;
    req_word_t  req_word;

    // pixel side
    logic       pix_valid;
    logic       pix_stall;
    pix_word_t  pix_word;

    // register writes
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    tile_glyph_pixel_renderer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_word  (pix_word),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // private copy of the block state
    logic [GLYPH_W-1:0] glyph_rows [STORE_ROWS];
    logic [COLOR_W-1:0] palette [4];
    logic               skip_zero;

    req_word_t pending_q [$];     // request words not yet offered
    pix_word_t pixel_due_q [$];   // pixel words predicted, not yet seen

    int err_count;
    int cycle_count;
    int n_loads;
    int n_puts;
    int n_pixels;
    int n_settings;

    logic req_taken;              // request word accepted at the last edge
    int   gap_left;
    int   burst_left;
    int   stall_mode;
    int   stall_left;

    // -----------------------------------------------------------------------
    // clock and cycle guard
    // -----------------------------------------------------------------------
    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // hard stop if the block hangs or drops words
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pixel words still due",
                     cycle_count, pixel_due_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // mismatch reporting
    // -----------------------------------------------------------------------
    // counts every mismatch, prints only the first few to keep the log short
    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("pixel %0d %s got 0x%0h want 0x%0h",
                                      n_pixels, name, got, want));
    endtask

    task automatic compare_pixel(input pix_word_t got, input pix_word_t want);
        if ($isunknown(got))
            report_mismatch($sformatf("pixel %0d has unknown bits", n_pixels));
        check_field("pixel_x",      got.pixel_x,      want.pixel_x);
        check_field("pixel_y",      got.pixel_y,      want.pixel_y);
        check_field("red",          got.red,          want.red);
        check_field("green",        got.green,        want.green);
        check_field("blue",         got.blue,         want.blue);
        check_field("write_enable", got.write_enable, want.write_enable);
        check_field("last",         got.last,         want.last);
    endtask

    // -----------------------------------------------------------------------
    // predictor: register file, glyph store and pixel expansion
    // -----------------------------------------------------------------------
    task automatic apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_COLOR_0:   palette[0] = data[COLOR_W-1:0];
            REG_COLOR_1:   palette[1] = data[COLOR_W-1:0];
            REG_COLOR_2:   palette[2] = data[COLOR_W-1:0];
            REG_COLOR_3:   palette[3] = data[COLOR_W-1:0];
            REG_SKIP_ZERO: skip_zero  = data[0];
            default:       ;   // unmapped index, write dropped
        endcase
    endtask

    task automatic store_row(input req_word_t w);
        // codes beyond the store size are dropped
        if (int'(w.char_code) < GLYPH_COUNT_DEF)
            glyph_rows[int'(w.char_code) * 8 + int'(w.glyph_row)] =
                {w.plane_high, w.plane_low};
    endtask

    // expands one put word into its 64 pixel words, row-major
    task automatic predict_glyph_pixels(input req_word_t w);
        logic [GLYPH_W-1:0] row_bits;
        logic [1:0]         color_idx;
        logic [COLOR_W-1:0] rgb;
        pix_word_t          px;
        int                 bit_pos;
        for (int dy = 0; dy < 8; dy++)
        begin
            // glyph out of range draws as all-zero rows
            if (int'(w.char_code) < GLYPH_COUNT_DEF)
                row_bits = glyph_rows[int'(w.char_code) * 8 + dy];
            else
                row_bits = '0;
            for (int dx = 0; dx < 8; dx++)
            begin
                bit_pos   = 7 - dx;   // column 0 is the msb of each plane
                color_idx = {row_bits[PLANE_W + bit_pos], row_bits[bit_pos]};
                rgb       = palette[color_idx];
                px.pixel_x      = COORD_W'(8 * int'(w.cell_x) + dx);
                px.pixel_y      = COORD_W'(8 * int'(w.cell_y) + dy);
                px.write_enable = !(skip_zero && color_idx == 2'd0);
                // transparent pixels carry black
                px.red   = px.write_enable ? rgb[23:16] : '0;
                px.green = px.write_enable ? rgb[15:8]  : '0;
                px.blue  = px.write_enable ? rgb[7:0]   : '0;
                px.last  = (dx == 7 && dy == 7);
                pixel_due_q.push_back(px);
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < STORE_ROWS; i++)
            glyph_rows[i] = '0;
        palette[0] = COLOR_0_RST;
        palette[1] = COLOR_1_RST;
        palette[2] = COLOR_2_RST;
        palette[3] = COLOR_3_RST;
        skip_zero  = 1'b0;
    end

    // -----------------------------------------------------------------------
    // monitor: mirrors accepted writes and words, checks pixel words
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        pix_word_t want;
        if (rst_n)
        begin
            if (cfg_write)
                apply_reg(cfg_index, cfg_data);
            if (req_valid && !req_stall)
            begin
                if (req_word.req_type == REQ_LOAD)
                begin
                    store_row(req_word);
                    n_loads++;
                end
                else
                begin
                    predict_glyph_pixels(req_word);
                    n_puts++;
                end
            end
            if (pix_valid && !pix_stall)
            begin
                if (pixel_due_q.size() == 0)
                    report_mismatch($sformatf("pixel word with none due: %h", pix_word));
                else
                begin
                    want = pixel_due_q.pop_front();
                    compare_pixel(pix_word, want);
                end
                n_pixels++;
            end
        end
        req_taken <= rst_n && req_valid && !req_stall;
    end

    // -----------------------------------------------------------------------
    // driver: request words in bursts with random gaps
    // -----------------------------------------------------------------------
    always @(negedge clk)
    begin
        req_word_t nxt;
        logic      drive;
        drive = 1'b0;
        nxt   = req_word;
        // a stalled word stays put until the block takes it
        if (rst_n && !(req_valid && !req_taken))
        begin
            if (gap_left > 0)
                gap_left--;
            else if (pending_q.size() > 0)
            begin
                nxt   = pending_q.pop_front();
                drive = 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 10);
                    // about a quarter of bursts run back to back
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            req_valid <= drive;
            req_word  <= nxt;
        end
    end

    // -----------------------------------------------------------------------
    // pixel stall pattern: free runs, light and heavy random, solid blocks
    // -----------------------------------------------------------------------
    always @(negedge clk)
    begin
        logic stall_now;
        if (stall_left <= 0)
        begin
            stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       stall_left = $urandom_range(20, 200);
                3:       stall_left = $urandom_range(1, 20);
                default: stall_left = $urandom_range(10, 100);
            endcase
        end
        stall_left--;
        case (stall_mode)
            0:       stall_now = 1'b0;
            1:       stall_now = ($urandom_range(0, 9) < 3);
            2:       stall_now = ($urandom_range(0, 3) != 0);
            default: stall_now = 1'b1;
        endcase
        pix_stall <= stall_now;
    end

    // -----------------------------------------------------------------------
    // stimulus helpers
    // -----------------------------------------------------------------------
    function automatic req_word_t make_req(input logic kind, input int code,
                                           input int row, input int lo,
                                           input int hi, input int cx,
                                           input int cy);
        req_word_t w;
        w.req_type   = kind;
        w.char_code  = CODE_W'(code);
        w.glyph_row  = ROW_W'(row);
        w.plane_low  = PLANE_W'(lo);
        w.plane_high = PLANE_W'(hi);
        w.cell_x     = CELL_W'(cx);
        w.cell_y     = CELL_W'(cy);
        return w;
    endfunction

    // plane byte, leaning on all-zero and all-one rows now and then
    function automatic int rand_plane();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic int rand_cell();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 31;
            default: return $urandom_range(0, 31);
        endcase
    endfunction

    function automatic int rand_code();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return GLYPH_COUNT_DEF - 1;
            default: return $urandom_range(0, GLYPH_COUNT_DEF - 1);
        endcase
    endfunction

    // waits out all queued and predicted traffic, then a settle period
    task automatic drain(input int settle);
        while (pending_q.size() > 0 || req_valid || pixel_due_q.size() > 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic write_palette(input logic [COLOR_W-1:0] c0, input logic [COLOR_W-1:0] c1,
                                 input logic [COLOR_W-1:0] c2, input logic [COLOR_W-1:0] c3,
                                 input logic [CFG_DATA_W-1:0] skip);
        write_reg(REG_COLOR_0, c0);
        write_reg(REG_COLOR_1, c1);
        write_reg(REG_COLOR_2, c2);
        write_reg(REG_COLOR_3, c3);
        write_reg(REG_SKIP_ZERO, skip);
        n_settings++;
    endtask

    // random traffic: mostly whole glyphs loaded then drawn, plus loose words
    task automatic queue_random_set(input int count);
        int made;
        int code;
        int lo;
        made = 0;
        while (made < count)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    code = rand_code();
                    for (int r = 0; r < 8; r++)
                        pending_q.push_back(make_req(REQ_LOAD, code, r, rand_plane(),
                                                     rand_plane(), $urandom_range(0, 31),
                                                     $urandom_range(0, 31)));
                    pending_q.push_back(make_req(REQ_PUT, code, $urandom_range(0, 7),
                                                 $urandom_range(0, 255),
                                                 $urandom_range(0, 255),
                                                 rand_cell(), rand_cell()));
                    made += 9;
                end
                6, 7:
                begin
                    // lone row update, often a row of an already drawn glyph
                    lo = rand_plane();
                    pending_q.push_back(make_req(REQ_LOAD, rand_code(), $urandom_range(0, 7),
                                                 lo, rand_plane(), $urandom_range(0, 31),
                                                 $urandom_range(0, 31)));
                    made++;
                end
                default:
                begin
                    pending_q.push_back(make_req(REQ_PUT, rand_code(), $urandom_range(0, 7),
                                                 $urandom_range(0, 255),
                                                 $urandom_range(0, 255),
                                                 rand_cell(), rand_cell()));
                    made++;
                end
            endcase
        end
    endtask

    // -----------------------------------------------------------------------
    // sequence: reset, directed words, then random traffic per palette set
    // -----------------------------------------------------------------------
    initial
    begin
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req_word   = '0;
        pix_stall  = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        req_taken  = 1'b0;
        gap_left   = 0;
        burst_left = 1;
        stall_mode = 0;
        stall_left = 0;
        err_count  = 0;
        cycle_count = 0;
        n_loads    = 0;
        n_puts     = 0;
        n_pixels   = 0;
        n_settings = 0;

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // directed, reset palette: untouched glyph draws all index 0
        pending_q.push_back(make_req(REQ_PUT, 5, 0, 0, 0, 0, 0));
        // last glyph: every index appears in every row
        for (int r = 0; r < 8; r++)
            pending_q.push_back(make_req(REQ_LOAD, GLYPH_COUNT_DEF - 1, r,
                                         8'h55 << (r & 1), 8'h33 << (r & 3),
                                         31, 31));
        // glyph 0: solid index 3 on top, index 2 at the bottom
        pending_q.push_back(make_req(REQ_LOAD, 0, 0, 8'hFF, 8'hFF, 0, 0));
        pending_q.push_back(make_req(REQ_LOAD, 0, 7, 8'h00, 8'hFF, 0, 0));
        // corner cells
        pending_q.push_back(make_req(REQ_PUT, GLYPH_COUNT_DEF - 1, 7, 255, 255, 31, 31));
        pending_q.push_back(make_req(REQ_PUT, GLYPH_COUNT_DEF - 1, 0, 0, 0, 0, 31));
        pending_q.push_back(make_req(REQ_PUT, 0, 7, 255, 0, 31, 0));
        pending_q.push_back(make_req(REQ_PUT, 0, 0, 0, 255, 0, 0));
        drain(LOAD_SETTLE);

        // transparency on, palette at its lowest, a junk write to each spare index
        write_palette('0, '0, '0, '0, 24'h000001);
        write_reg(REG_UNMAPPED_5, 24'hFFFFFF);
        write_reg(REG_UNMAPPED_6, 24'hFFFFFF);
        write_reg(REG_UNMAPPED_7, 24'hA5A5A5);
        pending_q.push_back(make_req(REQ_PUT, GLYPH_COUNT_DEF - 1, 0, 0, 0, 16, 8));
        pending_q.push_back(make_req(REQ_PUT, 0, 0, 0, 0, 1, 30));
        queue_random_set(ITEMS_PER_SET);
        drain(LOAD_SETTLE);

        // palette at its highest, upper data bits set on the transparency write
        write_palette('1, '1, '1, '1, 24'hFFFFFE);
        queue_random_set(ITEMS_PER_SET);
        drain(LOAD_SETTLE);

        // random palette and transparency
        write_palette(COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                      COLOR_W'($urandom), CFG_DATA_W'($urandom));
        write_reg(REG_UNMAPPED_5 + CFG_INDEX_W'($urandom_range(0, 2)),
                  CFG_DATA_W'($urandom));
        queue_random_set(ITEMS_PER_SET);
        drain(LOAD_SETTLE);

        // one more random palette with transparency forced on
        write_palette(COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                      COLOR_W'($urandom), 24'h000001);
        queue_random_set(ITEMS_PER_SET / 2);
        drain(PUT_HOLD);

        if (pixel_due_q.size() != 0)
            report_mismatch($sformatf("%0d pixel words never arrived", pixel_due_q.size()));

        $display("covered %0d row loads and %0d character draws, %0d pixel words checked",
                 n_loads, n_puts, n_pixels);
        $display("across %0d palette settings plus reset values, in %0d cycles",
                 n_settings, cycle_count);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
